// File: rtl/qdsr_pkg.sv
// ----------------------------------------------------------------------------
// qdsr_pkg
// Shared types, constants and helpers of the quadrature decoder readout core.
// ----------------------------------------------------------------------------
package qdsr_pkg;

    // Default sizing
    localparam int CHANNELS_DEF     = 6;
    localparam int COUNTER_BITS_DEF = 16;

    // Payload field widths
    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 3;
    localparam int PHASE_W   = 2;
    localparam int BYTE_W    = 8;
    localparam int S_TDATA_W = 16;   // channel, phase_bits, rx_byte, zero fill
    localparam int M_TDATA_W = 8;

    // Request kinds carried on tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_SELECT = 2'd1,
        CMD_RX     = 2'd2,
        CMD_TX     = 2'd3
    } cmd_t;

    // Received command bytes
    localparam logic [BYTE_W-1:0] RX_POSITIONS = 8'h55;
    localparam logic [BYTE_W-1:0] RX_ERRORS    = 8'hAA;

    // Place of a phase code in the forward cycle 00,10,11,01
    function automatic logic [PHASE_W-1:0] cycle_pos(input logic [PHASE_W-1:0] code);
        logic [PHASE_W-1:0] p;
        case (code)
            2'b00:   p = 2'd0;
            2'b10:   p = 2'd1;
            2'b11:   p = 2'd2;
            2'b01:   p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/quadrature_decoder_spi_readout_core.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_spi_readout_core
// Multi-channel quadrature decoder with position and error counts and a
// byte-serial snapshot readout.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle, back to back, save for the stall
// below. Requests pass an input register, then one short pass of per-channel
// counter logic and a byte select from the readout buffer, then the result
// register, where a byte that a request yields shows on the result port. All
// counters, phases and the 2*CHANNELS-byte buffer live in flip-flops and are
// cleared by reset, so no start-up sweep is needed. The input side stalls
// only while a result waits unclaimed and the next request also yields one.
module quadrature_decoder_spi_readout_core
    import qdsr_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [2:0] channel, [4:3] phase_bits,
                                                  // [12:5] rx_byte, [15:13] zero
    input  logic [CMD_W-1:0]      s_axis_tuser,   // [1:0] command

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata    // [7:0] tx_byte
);

    localparam int BYTES = 2 * CHANNELS;
    localparam int IDX_W = (BYTES > 1) ? $clog2(BYTES) : 1;
    localparam int PTR_W = $clog2(BYTES + 1);

    // Input register
    logic                  in_valid_reg;
    cmd_t                  cmd_reg;
    logic [CHAN_W-1:0]     chan_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [BYTE_W-1:0]     rx_reg;

    // Decoder and readout state
    logic [COUNTER_BITS-1:0] pos_reg   [CHANNELS];
    logic [COUNTER_BITS-1:0] pos_next  [CHANNELS];
    logic [COUNTER_BITS-1:0] err_reg   [CHANNELS];
    logic [COUNTER_BITS-1:0] err_next  [CHANNELS];
    logic [PHASE_W-1:0]      ph_reg    [CHANNELS];
    logic [PHASE_W-1:0]      ph_next   [CHANNELS];
    logic [BYTE_W-1:0]       rbuf_reg  [BYTES];
    logic [BYTE_W-1:0]       rbuf_next [BYTES];
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;

    // Result register
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     tx_reg;
    logic [BYTE_W-1:0]     tx_next;

    logic                  has_result;
    logic                  out_free;
    logic                  proceed;
    logic [IDX_W-1:0]      tx_idx;
    logic [COUNTER_BITS-1:0] pos_clr [CHANNELS];
    logic [PHASE_W-1:0]      step    [CHANNELS];
    logic [15:0]             src16   [CHANNELS];

    // Handshake: the staged request moves on when it yields no result or its result has room
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proceed       = in_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !in_valid_reg || proceed;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tx_reg;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg   <= cmd_t'(s_axis_tuser);
            chan_reg  <= s_axis_tdata[2:0];
            phase_reg <= s_axis_tdata[4:3];
            rx_reg    <= s_axis_tdata[12:5];
        end
    end

    // Work out the next state and the result byte
    always_comb begin
        pos_next   = pos_reg;
        err_next   = err_reg;
        ph_next    = ph_reg;
        rbuf_next  = rbuf_reg;
        ptr_next   = ptr_reg;
        tx_next    = tx_reg;
        has_result = 1'b0;

        // Per-channel all-ones clear, phase step and snapshot source
        for (int i = 0; i < CHANNELS; i++) begin
            pos_clr[i] = (pos_reg[i] == '1) ? '0 : pos_reg[i];
            step[i]    = cycle_pos(phase_reg) - cycle_pos(ph_reg[i]);
            src16[i]   = (rx_reg == RX_ERRORS) ? 16'(err_reg[i]) : 16'(pos_reg[i]);
        end

        // Wrap the pointer at the buffer end before a transmit
        tx_idx = (ptr_reg >= PTR_W'(BYTES)) ? '0 : ptr_reg[IDX_W-1:0];

        case (cmd_reg)
            CMD_SAMPLE: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(chan_reg) == i) begin
                        pos_next[i] = pos_clr[i];
                        ph_next[i]  = phase_reg;
                        case (step[i])
                            2'd1:    pos_next[i] = pos_clr[i] + 1'b1;
                            2'd3:    pos_next[i] = pos_clr[i] - 1'b1;
                            2'd2:    err_next[i] = err_reg[i] + 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            CMD_SELECT: begin
                ptr_next = '0;
            end
            CMD_RX: begin
                if (rx_reg == RX_POSITIONS || rx_reg == RX_ERRORS) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        rbuf_next[2*i]   = src16[i][7:0];
                        rbuf_next[2*i+1] = src16[i][15:8];
                    end
                    tx_next    = src16[0][7:0];
                    ptr_next   = PTR_W'(1);
                    has_result = 1'b1;
                end
            end
            CMD_TX: begin
                tx_next    = rbuf_reg[tx_idx];
                ptr_next   = PTR_W'(tx_idx) + PTR_W'(1);
                has_result = 1'b1;
            end
            default: ;
        endcase
    end

    // Commit the state when the request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i] <= '0;
                err_reg[i] <= '0;
                ph_reg[i]  <= '0;
            end
            for (int j = 0; j < BYTES; j++) begin
                rbuf_reg[j] <= '0;
            end
            ptr_reg <= '0;
        end else if (proceed) begin
            pos_reg  <= pos_next;
            err_reg  <= err_next;
            ph_reg   <= ph_next;
            rbuf_reg <= rbuf_next;
            ptr_reg  <= ptr_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proceed && has_result) begin
            tx_reg <= tx_next;
        end
    end

    // Checks
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_W'(BYTES))
        else $error("readout pointer beyond buffer end");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && has_result |=> out_valid_reg && tx_reg == $past(tx_next))
        else $error("result byte not loaded");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proceed |=> in_valid_reg && $stable(cmd_reg) && $stable(rx_reg))
        else $error("stalled request lost");

    a_snapshot_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && cmd_reg == CMD_RX && has_result |=> ptr_reg == PTR_W'(1))
        else $error("snapshot did not set pointer to one");

    a_select_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && cmd_reg == CMD_SELECT |=> ptr_reg == '0)
        else $error("select did not rewind pointer");

endmodule

// File: test/quadrature_decoder_spi_readout_core_tb.sv
// ----------------------------------------------------------------------------
// quadrature_decoder_spi_readout_core_tb
// Drives phase samples, select events, command bytes and transmit slots into
// the decoder. A scoreboard keeps its own copy of the counters and the readout
// buffer, predicts every readout byte and checks each one the block returns.
// Both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module quadrature_decoder_spi_readout_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qdsr_pkg::*;

    localparam int READOUT_BYTES   = 2 * CHANNELS_DEF;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 300;

    // Forward cycle 00,10,11,01: code at each place and place of each code
    localparam logic [1:0] FWD_CODE [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
    localparam logic [1:0] FWD_PLACE[4] = '{2'd0, 2'd3, 2'd1, 2'd2};

    // ------------------------------------------------------------------------
    // Scoreboard: counter state, readout buffer and expected readout bytes
    // ------------------------------------------------------------------------
    class readout_scoreboard;
        logic [COUNTER_BITS_DEF-1:0] position [CHANNELS_DEF];
        logic [COUNTER_BITS_DEF-1:0] jumps    [CHANNELS_DEF];
        logic [1:0]                  phase    [CHANNELS_DEF];
        logic [7:0]                  snap     [READOUT_BYTES];
        int unsigned                 rd_ptr;
        logic [7:0]                  tx_bytes[$];
        int                          failures;
        int                          matched;

        function new();
            for (int i = 0; i < CHANNELS_DEF; i++) begin
                position[i] = '0;
                jumps[i]    = '0;
                phase[i]    = 2'b00;
            end
            for (int i = 0; i < READOUT_BYTES; i++) begin
                snap[i] = 8'h00;
            end
            rd_ptr   = 0;
            failures = 0;
            matched  = 0;
        endfunction

        function int pending();
            return tx_bytes.size();
        endfunction

        // Advance the state by one accepted request and queue its readout byte
        function void note_request(cmd_t cmd, logic [S_TDATA_W-1:0] data);
            logic [2:0]                  ch;
            logic [1:0]                  ph;
            logic [7:0]                  rx;
            logic [1:0]                  delta;
            logic [COUNTER_BITS_DEF-1:0] src;
            ch = data[2:0];
            ph = data[4:3];
            rx = data[12:5];
            case (cmd)
                CMD_SAMPLE: begin
                    if (ch < CHANNELS_DEF) begin
                        // clear an all-ones position before the step
                        if (&position[ch]) begin
                            position[ch] = '0;
                        end
                        delta = FWD_PLACE[ph] - FWD_PLACE[phase[ch]];
                        if (delta == 2'd1) begin
                            position[ch] = position[ch] + 1'b1;
                        end else if (delta == 2'd3) begin
                            position[ch] = position[ch] - 1'b1;
                        end else if (delta == 2'd2) begin
                            jumps[ch] = jumps[ch] + 1'b1;
                        end
                        phase[ch] = ph;
                    end
                end
                CMD_SELECT: begin
                    rd_ptr = 0;
                end
                CMD_RX: begin
                    if (rx == RX_POSITIONS || rx == RX_ERRORS) begin
                        for (int i = 0; i < CHANNELS_DEF; i++) begin
                            src             = (rx == RX_POSITIONS) ? position[i] : jumps[i];
                            snap[2 * i]     = src[7:0];
                            snap[2 * i + 1] = src[15:8];
                        end
                        tx_bytes.push_back(snap[0]);
                        rd_ptr = 1;
                    end
                end
                CMD_TX: begin
                    if (rd_ptr >= READOUT_BYTES) begin
                        rd_ptr = 0;
                    end
                    tx_bytes.push_back(snap[rd_ptr]);
                    rd_ptr++;
                end
                default: ;
            endcase
        endfunction

        // Compare a returned byte with the oldest expectation
        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (tx_bytes.size() == 0) begin
                $error("tx_byte: none expected, got 0x%02h", got);
                failures++;
            end else begin
                want = tx_bytes.pop_front();
                if (got !== want) begin
                    $error("tx_byte: expected 0x%02h, got 0x%02h", want, got);
                    failures++;
                end else begin
                    matched++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]     s_axis_tuser  = CMD_SAMPLE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    readout_scoreboard sb = new();

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic [1:0] drive_phase[CHANNELS_DEF] = '{default: 2'b00};
    int        n_samples = 0;
    int        n_rx      = 0;
    int        n_tx      = 0;
    int        n_select  = 0;

    quadrature_decoder_spi_readout_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Check returned bytes and stall the result side at random
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------------
    task automatic send_request(input cmd_t cmd, input logic [2:0] ch,
                                input logic [1:0] ph, input logic [7:0] rx);
        logic [S_TDATA_W-1:0] data;
        data = {3'b000, rx, ph, ch};
        // idle the sender at random before the request
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(cmd, data);
        case (cmd)
            CMD_SAMPLE: n_samples++;
            CMD_RX:     n_rx++;
            CMD_TX:     n_tx++;
            default:    n_select++;
        endcase
    endtask

    task automatic send_sample(input logic [2:0] ch, input logic [1:0] ph,
                               input logic [7:0] rx);
        if (ch < CHANNELS_DEF) begin
            drive_phase[ch] = ph;
        end
        send_request(CMD_SAMPLE, ch, ph, rx);
    endtask

    // Mostly legal steps, jumps, repeats, noise, stray channels; also RX, TX, select
    task automatic send_random_request();
        int         pick;
        int         kind;
        logic [2:0] ch;
        logic [1:0] ph;
        logic [7:0] rx;
        pick = $urandom_range(99);
        ch   = 3'($urandom_range(CHANNELS_DEF - 1));
        ph   = 2'($urandom_range(3));
        rx   = 8'($urandom_range(255));
        if (pick < 58) begin
            if ($urandom_range(9) == 0) begin
                ch = 3'($urandom_range(7, CHANNELS_DEF));
            end else begin
                kind = $urandom_range(9);
                if (kind < 7) begin
                    ph = FWD_CODE[FWD_PLACE[drive_phase[ch]] + ($urandom_range(1) ? 2'd1 : 2'd3)];
                end else if (kind == 7) begin
                    ph = FWD_CODE[FWD_PLACE[drive_phase[ch]] + 2'd2];
                end else if (kind == 8) begin
                    ph = drive_phase[ch];
                end
            end
            send_sample(ch, ph, rx);
        end else if (pick < 70) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                rx = RX_POSITIONS;
            end else if (kind < 8) begin
                rx = RX_ERRORS;
            end
            send_request(CMD_RX, ch, ph, rx);
        end else if (pick < 94) begin
            send_request(CMD_TX, ch, ph, rx);
        end else begin
            send_request(CMD_SELECT, ch, ph, rx);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // hold reset, then release it
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: read the cleared buffer, steps, jumps, wrap and stray bytes
        send_request(CMD_TX, 3'd0, 2'b00, 8'h00);
        send_sample(3'd0, 2'b10, 8'h00);
        send_sample(3'd0, 2'b11, 8'h00);
        send_sample(3'd0, 2'b11, 8'h00);
        send_sample(3'd0, 2'b00, 8'h00);
        send_sample(3'd1, 2'b01, 8'h00);
        send_sample(3'd1, 2'b01, 8'h00);
        send_sample(3'd5, 2'b10, 8'h00);
        send_sample(3'd7, 2'b11, 8'hFF);
        send_request(CMD_RX, 3'd0, 2'b00, RX_POSITIONS);
        for (int i = 0; i < READOUT_BYTES; i++) begin
            send_request(CMD_TX, 3'd0, 2'b00, 8'h00);
        end
        send_request(CMD_RX, 3'd0, 2'b00, RX_ERRORS);
        send_request(CMD_SELECT, 3'd7, 2'b11, 8'hFF);
        send_request(CMD_TX, 3'd0, 2'b00, 8'h00);
        send_request(CMD_RX, 3'd0, 2'b00, 8'h00);

        // random phases: no idling, idle sender, stalling receiver, both lightly
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 51 : (p == 3) ? 7 : 0;
            recv_stall_pct = (p == 2) ? 51 : (p == 3) ? 7 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // drain every outstanding byte once, midway through the idle-sender phase
                if (p == 1 && n == ITEMS_PER_PHASE / 2) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (sb.pending() != 0) @(posedge aclk);
                end
                send_random_request();
            end
        end

        // drop valid and let the last bytes come out
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered %0d phase samples, %0d command bytes, %0d transmit slots, %0d selects",
                 n_samples, n_rx, n_tx, n_select);
        $display("Checked %0d readout bytes, %0d mismatches", sb.matched, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
